### hw/rtl/block_map_with_fifo_free_list_assert.svh
// assertion macros for the block map rtl
`ifndef BLOCK_MAP_WITH_FIFO_FREE_LIST_ASSERT_SVH
`define BLOCK_MAP_WITH_FIFO_FREE_LIST_ASSERT_SVH

`ifndef SYNTHESIS
`define BMF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
`define BMF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`define BMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define BMF_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define BMF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/bmfl_pkg.sv
// types and constants of the block map with fifo free list
package bmfl_pkg;

    localparam int CMD_W      = 2;
    localparam int KEY_W      = 64;
    localparam int ST_W       = 2;
    localparam int BLK_OUT_W  = 8;
    localparam int CFG_W      = 9;
    localparam int DEF_BLOCKS = 256;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_FREE   = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic init_start;
        logic init_step;
        logic accept;
        logic scan_step;
        logic update;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic idx_last;
        logic out_free;
    } t_ctl_stat;

endpackage

### hw/rtl/bmfl_ram.sv
// generic single-write, single-read ram with registered read data
module bmfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bmfl_ctrl.sv
// controller state machine: init sweep, table scan, update and result hand-off
module bmfl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_cfg_we,
    input  bmfl_pkg::t_ctl_stat  i_stat,
    output bmfl_pkg::t_ctl_cmd   o_cmd,
    output logic                 o_stall
);
    import bmfl_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_ctl_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (i_stat.idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_stat.idx_last) n_state = S_DRAIN;
            end
            // last table read is compared here
            S_DRAIN: n_state = S_UPD;
            S_UPD: begin
                cmd.update = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
        // a register write restarts the init sweep
        if (i_cfg_we) begin
            cmd            = '0;
            cmd.init_start = 1'b1;
            n_state        = S_INIT;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE) || i_cfg_we;

endmodule

### hw/rtl/bmfl_dpath.sv
// datapath: entry table, free ring, scan compare, queue pointers and output register
`include "block_map_with_fifo_free_list_assert.svh"
module bmfl_dpath #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bmfl_pkg::t_ctl_cmd              i_cmd,
    output bmfl_pkg::t_ctl_stat             o_stat,
    input  logic [bmfl_pkg::CMD_W-1:0]      i_command,
    input  logic [bmfl_pkg::KEY_W-1:0]      i_key,
    input  logic [bmfl_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [bmfl_pkg::ST_W-1:0]       o_status,
    output logic [bmfl_pkg::BLK_OUT_W-1:0]  o_block,
    output logic                            o_was_present
);
    import bmfl_pkg::*;

    localparam int AW  = $clog2(NUM_BLOCKS);
    localparam int CW  = $clog2(NUM_BLOCKS + 1);
    localparam int EW  = 1 + KEY_W + AW;
    localparam int RST_BLOCKS = (DEF_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS : DEF_BLOCKS;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0] RST_CNT  = CW'(RST_BLOCKS);
    localparam logic [AW-1:0] RST_TAIL = (RST_BLOCKS == NUM_BLOCKS) ? '0 : AW'(RST_BLOCKS);

    // control state
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_cmp_vld;
    logic          r_hit;
    logic          r_emp;
    logic          r_o_valid;

    // payload
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [AW-1:0]    r_cmp_idx;
    logic [AW-1:0]    r_hit_idx;
    logic [AW-1:0]    r_hit_blk;
    logic [AW-1:0]    r_emp_idx;
    logic [ST_W-1:0]  r_res_status, res_status;
    logic [AW-1:0]    r_res_block, res_block;
    logic             r_res_present, res_present;
    logic [ST_W-1:0]  r_o_status;
    logic [AW-1:0]    r_o_block;
    logic             r_o_present;

    // memories
    logic          ent_we;
    logic [AW-1:0] ent_waddr;
    logic [EW-1:0] ent_wdata;
    logic [EW-1:0] ent_rdata;
    logic          ring_we;
    logic [AW-1:0] ring_waddr;
    logic [AW-1:0] ring_wdata;
    logic [AW-1:0] ring_rdata;

    logic             rd_valid;
    logic [KEY_W-1:0] rd_key;
    logic [AW-1:0]    rd_blk;
    logic [AW-1:0]    head_inc;
    logic [AW-1:0]    tail_inc;
    logic [CW-1:0]    cfg_cnt;
    logic [AW-1:0]    cfg_tail;
    logic             out_take;

    bmfl_ram #(.WIDTH(EW), .DEPTH(NUM_BLOCKS)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (r_idx),
        .o_rdata (ent_rdata)
    );

    // head is the only ring read address, so the popped block is always waiting
    bmfl_ram #(.WIDTH(AW), .DEPTH(NUM_BLOCKS)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (r_head),
        .o_rdata (ring_rdata)
    );

    assign rd_valid = ent_rdata[EW-1];
    assign rd_key   = ent_rdata[EW-2 -: KEY_W];
    assign rd_blk   = ent_rdata[AW-1:0];
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;

    // block count clipped to the ring depth
    always_comb begin
        if (int'(i_cfg_data) >= NUM_BLOCKS) begin
            cfg_cnt = FULL_CNT;
        end else begin
            cfg_cnt = CW'(i_cfg_data);
        end
        cfg_tail = (cfg_cnt == FULL_CNT) ? '0 : cfg_cnt[AW-1:0];
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        ent_we      = 1'b0;
        ent_waddr   = r_hit_idx;
        ent_wdata   = {1'b0, r_key, ring_rdata};
        ring_we     = 1'b0;
        ring_waddr  = r_tail;
        ring_wdata  = r_hit_blk;
        res_status  = ST_OK;
        res_block   = '0;
        res_present = r_hit;
        if (i_cmd.init_step) begin
            ent_we     = 1'b1;
            ent_waddr  = r_idx;
            ent_wdata  = '0;
            ring_we    = 1'b1;
            ring_waddr = r_idx;
            ring_wdata = r_idx;
        end else if (i_cmd.update) begin
            unique case (r_cmd)
                CMD_LOOKUP: begin
                    if (r_hit) begin
                        res_block = r_hit_blk;
                    end else begin
                        res_status = ST_NOT_FOUND;
                    end
                end
                CMD_WRITE: begin
                    if ((r_count == '0) || (!r_hit && !r_emp)) begin
                        res_status = ST_NO_FREE;
                    end else begin
                        n_head    = head_inc;
                        ent_we    = 1'b1;
                        ent_waddr = r_hit ? r_hit_idx : r_emp_idx;
                        ent_wdata = {1'b1, r_key, ring_rdata};
                        res_block = ring_rdata;
                        // remap: old block goes to the tail, count stays
                        if (r_hit) begin
                            ring_we = 1'b1;
                            n_tail  = tail_inc;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (r_hit) begin
                        res_block = r_hit_blk;
                        ent_we    = 1'b1;
                        if (r_count < FULL_CNT) begin
                            ring_we = 1'b1;
                            n_tail  = tail_inc;
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                default: res_present = 1'b0;
            endcase
        end
    end

    assign out_take = r_o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_head    <= '0;
            r_tail    <= RST_TAIL;
            r_count   <= RST_CNT;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_emp     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step;
            if (i_cmd.init_start) begin
                r_idx   <= '0;
                r_head  <= '0;
                r_tail  <= cfg_tail;
                r_count <= cfg_cnt;
            end else begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                if (i_cmd.accept) begin
                    r_idx <= '0;
                end else if (i_cmd.init_step || i_cmd.scan_step) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.accept) begin
                r_hit <= 1'b0;
                r_emp <= 1'b0;
            end else if (r_cmp_vld) begin
                // first matching valid entry and first free entry
                if (rd_valid && (rd_key == r_key) && !r_hit) r_hit <= 1'b1;
                if (!rd_valid && !r_emp) r_emp <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (out_take) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (i_cmd.accept) begin
            r_cmd <= i_command;
            r_key <= i_key;
        end
        if (r_cmp_vld && !i_cmd.accept) begin
            if (rd_valid && (rd_key == r_key) && !r_hit) begin
                r_hit_idx <= r_cmp_idx;
                r_hit_blk <= rd_blk;
            end
            if (!rd_valid && !r_emp) r_emp_idx <= r_cmp_idx;
        end
        if (i_cmd.update) begin
            r_res_status  <= res_status;
            r_res_block   <= res_block;
            r_res_present <= res_present;
        end
        if (i_cmd.out_load) begin
            r_o_status  <= r_res_status;
            r_o_block   <= r_res_block;
            r_o_present <= r_res_present;
        end
    end

    assign o_stat.idx_last = (r_idx == LAST_IDX);
    assign o_stat.out_free = !r_o_valid || !i_stall;
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_block         = BLK_OUT_W'(r_o_block);
    assign o_was_present   = r_o_present;

    // tail sits count places after head around the ring
    `BMF_ASSERT_ALWAYS(a_ring_ptrs, i_clk, i_rst_n, (int'(r_head) + int'(r_count) == int'(r_tail)) || (int'(r_head) + int'(r_count) == int'(r_tail) + NUM_BLOCKS))
    `BMF_ASSERT_IMPL(a_nf_absent, i_clk, i_rst_n, r_o_valid && (r_o_status == ST_NOT_FOUND), !r_o_present && (r_o_block == '0))
    `BMF_ASSERT_NEXT(a_nofree_same, i_clk, i_rst_n, i_cmd.update && (res_status == ST_NO_FREE), (r_count == $past(r_count)) && (r_head == $past(r_head)))

endmodule

### hw/rtl/block_map_with_fifo_free_list.sv
// an accepted item runs through a full scan of the entry table ram, a drain, an update and the
// hand-off to the output register; a new item is taken only after that hand-off
// the next item is accepted while an earlier result still waits in the output register
// reset and every blocks_in_use write start an init sweep over the whole table that clears
// the table and refills the free ring; no item is accepted during the sweep
module block_map_with_fifo_free_list #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bmfl_pkg::CMD_W-1:0]      i_command,
    input  logic [bmfl_pkg::KEY_W-1:0]      i_key,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bmfl_pkg::ST_W-1:0]       o_status,
    output logic [bmfl_pkg::BLK_OUT_W-1:0]  o_block,
    output logic                            o_was_present,
    input  logic                            i_cfg_we,
    input  logic [bmfl_pkg::CFG_W-1:0]      i_cfg_data
);
    import bmfl_pkg::*;

    t_ctl_cmd  ctl_cmd;
    t_ctl_stat ctl_stat;

    bmfl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cfg_we (i_cfg_we),
        .i_stat   (ctl_stat),
        .o_cmd    (ctl_cmd),
        .o_stall  (o_stall)
    );

    bmfl_dpath #(.NUM_BLOCKS(NUM_BLOCKS)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctl_cmd),
        .o_stat        (ctl_stat),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_block       (o_block),
        .o_was_present (o_was_present)
    );

endmodule
